// ===== rtl/rc4_pkg.sv =====
`default_nettype none

package rc4_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned PERM_DEPTH  = 256;
	localparam int unsigned KEY_MAX_DEF = 256;

	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam int unsigned OP_W = 4;

	localparam logic [OP_W-1:0] OP_NONE = 4'd0;
	localparam logic [OP_W-1:0] OP_INIT = 4'd1;
	localparam logic [OP_W-1:0] OP_KRD  = 4'd2;
	localparam logic [OP_W-1:0] OP_KJ   = 4'd3;
	localparam logic [OP_W-1:0] OP_KW1  = 4'd4;
	localparam logic [OP_W-1:0] OP_KW2  = 4'd5;
	localparam logic [OP_W-1:0] OP_PRD  = 4'd6;
	localparam logic [OP_W-1:0] OP_PJ   = 4'd7;
	localparam logic [OP_W-1:0] OP_PW1  = 4'd8;
	localparam logic [OP_W-1:0] OP_PW2  = 4'd9;
	localparam logic [OP_W-1:0] OP_PKS  = 4'd10;
	localparam logic [OP_W-1:0] OP_EMIT = 4'd11;

	typedef struct packed {
		logic            key_wr;
		logic            data_ld;
		logic [OP_W-1:0] op;
	} ctl_cmd_t;

	typedef struct packed {
		logic n_last;
		logic keyed;
		logic out_free;
	} ctl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rc4_ctrl.sv =====
`default_nettype none

module rc4_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_cmd,
	input  logic                 in_last,
	output logic                 in_ready,
	input  rc4_pkg::ctl_stat_t   stat,
	output rc4_pkg::ctl_cmd_t    cmd
);
	import rc4_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_KRD  = 4'd2;
	localparam logic [3:0] S_KJ   = 4'd3;
	localparam logic [3:0] S_KW1  = 4'd4;
	localparam logic [3:0] S_KW2  = 4'd5;
	localparam logic [3:0] S_PRD  = 4'd6;
	localparam logic [3:0] S_PJ   = 4'd7;
	localparam logic [3:0] S_PW1  = 4'd8;
	localparam logic [3:0] S_PW2  = 4'd9;
	localparam logic [3:0] S_PKS  = 4'd10;
	localparam logic [3:0] S_EMIT = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_DATA) begin
						cmd.data_ld = 1'b1;
						state_nxt   = stat.keyed ? S_PRD : S_EMIT;
					end else begin
						cmd.key_wr = 1'b1;
						if (in_last) begin
							state_nxt = S_INIT;
						end
					end
				end
			end
			S_INIT: begin
				cmd.op = OP_INIT;
				if (stat.n_last) begin
					state_nxt = S_KRD;
				end
			end
			S_KRD: begin
				cmd.op    = OP_KRD;
				state_nxt = S_KJ;
			end
			S_KJ: begin
				cmd.op    = OP_KJ;
				state_nxt = S_KW1;
			end
			S_KW1: begin
				cmd.op    = OP_KW1;
				state_nxt = S_KW2;
			end
			S_KW2: begin
				cmd.op    = OP_KW2;
				state_nxt = stat.n_last ? S_IDLE : S_KRD;
			end
			S_PRD: begin
				cmd.op    = OP_PRD;
				state_nxt = S_PJ;
			end
			S_PJ: begin
				cmd.op    = OP_PJ;
				state_nxt = S_PW1;
			end
			S_PW1: begin
				cmd.op    = OP_PW1;
				state_nxt = S_PW2;
			end
			S_PW2: begin
				cmd.op    = OP_PW2;
				state_nxt = S_PKS;
			end
			S_PKS: begin
				cmd.op    = OP_PKS;
				state_nxt = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.op    = OP_EMIT;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rc4_dp.sv =====
`default_nettype none

module rc4_dp #(
	parameter int unsigned KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rc4_pkg::ctl_cmd_t           cmd,
	output rc4_pkg::ctl_stat_t          stat,
	input  logic [rc4_pkg::BYTE_W-1:0]  byte_in,
	output logic [rc4_pkg::BYTE_W-1:0]  byte_out,
	output logic [rc4_pkg::BYTE_W-1:0]  keystream,
	output logic                        not_keyed,
	output logic                        out_valid,
	input  logic                        out_ready
);
	import rc4_pkg::*;

	localparam int unsigned KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int unsigned CW  = $clog2(KEY_MAX + 1);

	logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
	logic [BYTE_W-1:0] key_mem  [KEY_MAX];

	logic [CW-1:0]     key_count_q;
	logic [KAW-1:0]    kidx_q;
	logic [BYTE_W-1:0] n_q;
	logic [BYTE_W-1:0] i_q;
	logic [BYTE_W-1:0] j_q;
	logic              keyed_q;
	logic              out_valid_q;

	logic [BYTE_W-1:0] rd_q;
	logic [BYTE_W-1:0] kd_q;
	logic [BYTE_W-1:0] sa_q;
	logic [BYTE_W-1:0] t_q;
	logic              hit_q;
	logic [BYTE_W-1:0] ks_q;
	logic [BYTE_W-1:0] byte_q;
	logic              nk_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [BYTE_W-1:0] out_ks_q;
	logic              out_nk_q;

	logic              key_we;
	logic              kidx_wrap;
	logic [BYTE_W-1:0] i_inc;
	logic [BYTE_W-1:0] j_ksa;
	logic [BYTE_W-1:0] j_prga;
	logic              perm_we;
	logic [BYTE_W-1:0] perm_waddr;
	logic [BYTE_W-1:0] perm_wdata;
	logic [BYTE_W-1:0] perm_raddr;

	assign key_we    = cmd.key_wr && (key_count_q < CW'(KEY_MAX));
	assign kidx_wrap = ((CW'(kidx_q) + CW'(1)) == key_count_q);
	assign i_inc     = i_q + BYTE_W'(1);
	assign j_ksa     = j_q + rd_q + kd_q;
	assign j_prga    = j_q + rd_q;

	always_comb begin
		perm_we    = 1'b0;
		perm_waddr = n_q;
		perm_wdata = n_q;
		perm_raddr = n_q;
		case (cmd.op)
			OP_INIT: begin
				perm_we = 1'b1;
			end
			OP_KJ: begin
				perm_raddr = j_ksa;
			end
			OP_KW1: begin
				perm_we    = 1'b1;
				perm_wdata = rd_q;
			end
			OP_KW2: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = sa_q;
			end
			OP_PRD: begin
				perm_raddr = i_inc;
			end
			OP_PJ: begin
				perm_raddr = j_prga;
			end
			OP_PW1: begin
				perm_we    = 1'b1;
				perm_waddr = i_q;
				perm_wdata = rd_q;
			end
			OP_PW2: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = sa_q;
				perm_raddr = t_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_waddr] <= perm_wdata;
		end
		rd_q <= perm_mem[perm_raddr];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_count_q[KAW-1:0]] <= byte_in;
		end
		kd_q <= key_mem[kidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			kidx_q      <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			keyed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (key_we) begin
				key_count_q <= key_count_q + CW'(1);
			end
			case (cmd.op)
				OP_INIT: begin
					n_q    <= n_q + BYTE_W'(1);
					j_q    <= '0;
					kidx_q <= '0;
				end
				OP_KJ: begin
					j_q <= j_ksa;
				end
				OP_KW2: begin
					n_q    <= n_q + BYTE_W'(1);
					kidx_q <= kidx_wrap ? '0 : kidx_q + KAW'(1);
					if (n_q == '1) begin
						i_q         <= '0;
						j_q         <= '0;
						keyed_q     <= 1'b1;
						key_count_q <= '0;
					end
				end
				OP_PRD: begin
					i_q <= i_inc;
				end
				OP_PJ: begin
					j_q <= j_prga;
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.data_ld) begin
			byte_q <= byte_in;
			ks_q   <= '0;
			nk_q   <= ~keyed_q;
		end
		case (cmd.op) inside
			OP_KJ, OP_PJ: begin
				sa_q <= rd_q;
			end
			OP_PW1: begin
				t_q <= sa_q + rd_q;
			end
			OP_PW2: begin
				hit_q <= (t_q == j_q);
			end
			OP_PKS: begin
				ks_q <= hit_q ? sa_q : rd_q;
			end
			OP_EMIT: begin
				out_byte_q <= byte_q ^ ks_q;
				out_ks_q   <= ks_q;
				out_nk_q   <= nk_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.n_last   = (n_q == '1);
	assign stat.keyed    = keyed_q;
	assign stat.out_free = ~out_valid_q | out_ready;

	assign byte_out  = out_byte_q;
	assign keystream = out_ks_q;
	assign not_keyed = out_nk_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/rc4_stream_cipher.sv =====
// Key beats are taken one per cycle while idle; the beat flagged last starts the key schedule:
// an identity fill of the permutation RAM, then per entry a read, a j update and two swap writes.
// A keyed data beat steps through the read, j-update, swap-write, keystream and emit states, and
// until its result is loaded no new beat is taken; the permutation RAM has one read and one write port.
// An unkeyed data beat goes straight to the emit state, which waits for a free output register.
// Asynchronous active-low reset clears control, indices and key count; the RAMs are not cleared.
`default_nettype none

module rc4_stream_cipher #(
	parameter int unsigned KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] byte_in
	input  logic [0:0]  s_axis_tuser,  // [0] cmd
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] byte_out, [15:8] keystream
	output logic [0:0]  m_axis_tuser   // [0] not_keyed
);
	import rc4_pkg::*;

	ctl_cmd_t  cmd_w;
	ctl_stat_t stat_w;

	rc4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser[0]),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.stat     (stat_w),
		.cmd      (cmd_w)
	);

	rc4_dp #(
		.KEY_MAX (KEY_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_w),
		.stat      (stat_w),
		.byte_in   (s_axis_tdata),
		.byte_out  (m_axis_tdata[7:0]),
		.keystream (m_axis_tdata[15:8]),
		.not_keyed (m_axis_tuser[0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

`ifndef SYNTH
	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_w.op == OP_EMIT |-> stat_w.out_free)
		else $error("result loaded while the output register is still full");

	a_idle_no_ops: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> cmd_w.op == OP_NONE)
		else $error("RAM operation issued while accepting beats");

	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_DATA || s_axis_tlast)
		|=> !s_axis_tready)
		else $error("new beat accepted before the previous one was processed");

	a_unkeyed_zero_ks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:8] == 8'd0)
		else $error("unkeyed result carries a non-zero keystream");
`endif

endmodule

`default_nettype wire
